// File: hdl/dq_pkg.sv
// Shared types, constants and helper functions for the double-ended queue.
// Used by every module of the block and by its port checker.
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_WIDTH + CNT_W + 7) / 8) * 8;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR,
    OP_DUMP,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP,
    BK_DUMP
  } back_state_t;

  typedef struct packed {
    op_t                          op;
    logic signed [DATA_WIDTH-1:0] value;
  } req_t;

  function automatic op_t classify(input logic [CMD_W-1:0] cmd);
    op_t op;
    unique case (cmd)
      CMD_PUSH_FRONT: op = OP_PUSH_FRONT;
      CMD_PUSH_REAR:  op = OP_PUSH_REAR;
      CMD_POP_FRONT:  op = OP_POP_FRONT;
      CMD_POP_REAR:   op = OP_POP_REAR;
      CMD_DUMP:       op = OP_DUMP;
      default:        op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic ptr_t ring_add(input ptr_t base, input cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// File: hdl/double_ended_queue.sv
// Bounded double-ended queue of 16 words held in a ring store.
// Each request carries one command (push front, push rear, pop front, pop rear,
// dump) and gives one result, or one result per entry for a dump of a
// non-empty queue, with tlast on the final result. A push, a full or empty
// case and an unknown command load the result directly; a pop first reads the
// ring store, which has a registered read port; a dump makes one store read per
// entry. The first result passes through the input register, the two-entry
// request queue and the result register, and for a pop also the store read
// register. The front keeps taking requests while the back works or the result
// waits, until the request queue and the input register are full. The store
// needs no clearing after reset.
module double_ended_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dq_pkg::IN_TDATA_W-1:0]  s_tdata,  // [31:0] value_in
  input  logic [dq_pkg::CMD_W-1:0]       s_tuser,  // [2:0] cmd
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dq_pkg::OUT_TDATA_W-1:0] m_tdata,  // [31:0] value_out, [36:32] occupancy
  output logic [dq_pkg::STATUS_W-1:0]    m_tuser,  // [1:0] status
  output logic                           m_tlast
);
  import dq_pkg::*;

  logic q_wr_valid;
  logic q_wr_ready;
  req_t q_wr_req;
  logic q_rd_valid;
  logic q_rd_ready;
  req_t q_rd_req;

  dq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .q_wr_valid (q_wr_valid),
    .q_wr_ready (q_wr_ready),
    .q_wr_req   (q_wr_req)
  );

  dq_req_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_req   (q_wr_req),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_req   (q_rd_req)
  );

  dq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_rd_valid (q_rd_valid),
    .q_rd_ready (q_rd_ready),
    .q_rd_req   (q_rd_req),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

// File: hdl/dq_front.sv
// Front part of the double-ended queue: accepts requests and classifies them.
// Depends on dq_pkg for the request type and the command decoder.
module dq_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [dq_pkg::IN_TDATA_W-1:0] s_tdata,  // [31:0] value_in
  input  logic [dq_pkg::CMD_W-1:0]   s_tuser,     // [2:0] cmd
  output logic                       q_wr_valid,
  input  logic                       q_wr_ready,
  output dq_pkg::req_t               q_wr_req
);
  import dq_pkg::*;

  logic held_valid;
  req_t held_req;
  logic accept;

  assign s_tready   = !held_valid || q_wr_ready;
  assign accept     = s_tvalid && s_tready;
  assign q_wr_valid = held_valid;
  assign q_wr_req   = held_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (q_wr_ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_req.op    <= classify(s_tuser);
      held_req.value <= s_tdata[DATA_WIDTH-1:0];
    end
  end

endmodule

// File: hdl/dq_req_queue.sv
// Short request queue between the front and back parts of the double-ended queue.
// Depends on dq_pkg for the request type and the queue depth.
module dq_req_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  dq_pkg::req_t wr_req,
  output logic         rd_valid,
  input  logic         rd_ready,
  output dq_pkg::req_t rd_req
);
  import dq_pkg::*;

  req_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (fill != QCNT_W'(QDEPTH));
  assign rd_valid = (fill != '0);
  assign rd_req   = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_req;
    end
  end

endmodule

// File: hdl/dq_back.sv
// Back part of the double-ended queue: ring store, pointers, dump sequencer
// and the result register. Depends on dq_pkg.
module dq_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_rd_valid,
  output logic                           q_rd_ready,
  input  dq_pkg::req_t                   q_rd_req,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dq_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [dq_pkg::STATUS_W-1:0]    m_tuser,
  output logic                           m_tlast
);
  import dq_pkg::*;

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_data;

  back_state_t state;
  back_state_t state_next;
  ptr_t        front_idx;
  ptr_t        front_idx_next;
  cnt_t        count;
  cnt_t        count_next;
  cnt_t        dump_i;
  cnt_t        dump_i_next;

  logic                         wr_en;
  ptr_t                         wr_addr;
  logic                         rd_en;
  ptr_t                         rd_addr;
  logic                         load;
  logic [STATUS_W-1:0]          ld_status;
  logic signed [DATA_WIDTH-1:0] ld_value;
  cnt_t                         ld_occ;
  logic                         ld_last;
  logic                         slot_free;
  logic                         full;
  logic                         empty;
  ptr_t                         front_dec;

  logic signed [DATA_WIDTH-1:0] out_value;
  cnt_t                         out_occ;

  assign slot_free = !m_tvalid || m_tready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign front_dec = (front_idx == '0) ? PTR_W'(DEPTH - 1) : front_idx - 1'b1;
  assign m_tdata   = OUT_TDATA_W'({out_occ, out_value});

  always_comb begin
    state_next     = state;
    front_idx_next = front_idx;
    count_next     = count;
    dump_i_next    = dump_i;
    q_rd_ready     = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = front_dec;
    rd_en          = 1'b0;
    rd_addr        = front_idx;
    load           = 1'b0;
    ld_status      = ST_OK;
    ld_value       = '0;
    ld_occ         = count;
    ld_last        = 1'b1;
    unique case (state)
      BK_IDLE: begin
        if (q_rd_valid && slot_free) begin
          q_rd_ready = 1'b1;
          unique case (q_rd_req.op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              load = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
                ld_occ     = count + 1'b1;
                if (q_rd_req.op == OP_PUSH_FRONT) begin
                  front_idx_next = front_dec;
                end else begin
                  wr_addr = ring_add(front_idx, count);
                end
              end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                count_next = count - 1'b1;
                state_next = BK_POP;
                if (q_rd_req.op == OP_POP_FRONT) begin
                  front_idx_next = ring_add(front_idx, CNT_W'(1));
                end else begin
                  rd_addr = ring_add(front_idx, count - 1'b1);
                end
              end
            end
            OP_DUMP: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en       = 1'b1;
                dump_i_next = '0;
                state_next  = BK_DUMP;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      BK_POP: begin
        if (slot_free) begin
          load       = 1'b1;
          ld_value   = rd_data;
          state_next = BK_IDLE;
        end
      end
      BK_DUMP: begin
        if (slot_free) begin
          load     = 1'b1;
          ld_value = rd_data;
          ld_last  = (dump_i + 1'b1 == count);
          if (ld_last) begin
            state_next = BK_IDLE;
          end else begin
            dump_i_next = dump_i + 1'b1;
            rd_en       = 1'b1;
            rd_addr     = ring_add(front_idx, dump_i + 1'b1);
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      front_idx <= '0;
      count     <= '0;
      dump_i    <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      front_idx <= front_idx_next;
      count     <= count_next;
      dump_i    <= dump_i_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser   <= ld_status;
      out_value <= ld_value;
      out_occ   <= ld_occ;
      m_tlast   <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_rd_req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/dq_checker.sv
// Port checker for the double-ended queue and the bind that attaches it.
// Depends on dq_pkg for widths and status codes.
module dq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [dq_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [dq_pkg::STATUS_W-1:0]    m_tuser,
  input logic                           m_tlast
);
  import dq_pkg::*;

  logic [CNT_W-1:0]      occ;
  logic [DATA_WIDTH-1:0] val;

  assign occ = m_tdata[DATA_WIDTH+CNT_W-1:DATA_WIDTH];
  assign val = m_tdata[DATA_WIDTH-1:0];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("Result changed while stalled.");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> occ == CNT_W'(DEPTH) && val == '0 && m_tlast)
    else $error("Full result with wrong occupancy or data.");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_EMPTY |-> occ == '0 && val == '0 && m_tlast)
    else $error("Empty result with wrong occupancy or data.");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> occ <= CNT_W'(DEPTH) && m_tuser <= ST_FULL)
    else $error("Occupancy or status out of range.");

  a_dump_steady: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast ##1 m_tvalid |-> $stable(occ) && m_tuser == ST_OK)
    else $error("Occupancy moved within a dump.");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
